// ===== rtl/core/rrts_pkg.sv =====
// rrts_pkg: shared types and codes of the round-robin task scheduler
// no dependencies; imported by rrts_out_stage, rrts_ctrl, the top module and the checker
package rrts_pkg;

  localparam int ID_W    = 6;
  localparam int SLICE_W = 8;
  localparam int OP_W    = 2;
  localparam int STS_W   = 2;
  localparam int SST_W   = 2;

  // operations
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN    = 2'd1;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;
  localparam logic [OP_W-1:0] OP_SLEEP  = 2'd3;

  // result status
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_NO_SLOT = 2'd1;
  localparam logic [STS_W-1:0] STS_IGNORED = 2'd2;

  // slot states
  localparam logic [SST_W-1:0] SL_FREE  = 2'd0;
  localparam logic [SST_W-1:0] SL_ALLOC = 2'd1;
  localparam logic [SST_W-1:0] SL_RUN   = 2'd2;

  localparam logic [SLICE_W-1:0] INIT_SLICE = 8'd2;

  typedef struct packed {
    logic [SST_W-1:0]   st;
    logic [SLICE_W-1:0] slice;
  } slot_ent_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic [ID_W-1:0]    chosen_task;
    logic               timer_reload;
    logic [SLICE_W-1:0] reload_ticks;
    logic               do_jump;
  } res_t;

endpackage

// ===== rtl/core/rrts_ram.sv =====
// rrts_ram: simple dual-port memory, one write and one registered read per cycle
// no dependencies; holds the slot table and the run list
module rrts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rrts_out_stage.sv =====
// rrts_out_stage: result register between the sequencer and the output channel
// depends on rrts_pkg for the result type
module rrts_out_stage
  import rrts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  res_t               res,
  output logic               res_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STS_W-1:0]   out_status,
  output logic [ID_W-1:0]    out_chosen_task,
  output logic               out_timer_reload,
  output logic [SLICE_W-1:0] out_reload_ticks,
  output logic               out_do_jump
);

  logic out_valid_r;
  res_t data_r;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = data_r.status;
  assign out_chosen_task  = data_r.chosen_task;
  assign out_timer_reload = data_r.timer_reload;
  assign out_reload_ticks = data_r.reload_ticks;
  assign out_do_jump      = data_r.do_jump;

endmodule

// ===== rtl/core/rrts_ctrl.sv =====
// rrts_ctrl: sequencer that walks the slot table and run list memories
// depends on rrts_pkg; drives two rrts_ram instances and the result stage
module rrts_ctrl
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_W-1:0]               in_operation,
  input  logic [ID_W-1:0]               in_task_id,
  input  logic [SLICE_W-1:0]            in_slice_ticks,
  output logic                          res_valid,
  output res_t                          res,
  input  logic                          res_ready,
  // slot table memory
  output logic                          sm_we,
  output logic [$clog2(TASK_SLOTS)-1:0] sm_waddr,
  output slot_ent_t                     sm_wdata,
  output logic                          sm_re,
  output logic [$clog2(TASK_SLOTS)-1:0] sm_raddr,
  input  slot_ent_t                     sm_rdata,
  // run list memory
  output logic                          rl_we,
  output logic [$clog2(TASK_SLOTS)-1:0] rl_waddr,
  output logic [ID_W-1:0]               rl_wdata,
  output logic                          rl_re,
  output logic [$clog2(TASK_SLOTS)-1:0] rl_raddr,
  input  logic [ID_W-1:0]               rl_rdata
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TASK_SLOTS);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_ALLOC    = 11'b00000000100,
    S_RUN      = 11'b00000001000,
    S_SLP_CHK  = 11'b00000010000,
    S_SLP_WALK = 11'b00000100000,
    S_SLP_END  = 11'b00001000000,
    S_DISP     = 11'b00010000000,
    S_SW_LIST  = 11'b00100000000,
    S_SW_SLOT  = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [ID_W-1:0]    tid_r, tid_nxt;
  logic [SLICE_W-1:0] slc_r, slc_nxt;
  slot_ent_t          ent_r, ent_nxt;
  res_t               res_r, res_nxt;

  logic               id_ok;
  logic [CNT_W-1:0]   sw_pos;
  logic [IDX_W-1:0]   tid_idx;
  logic               append;
  logic [IDX_W-1:0]   disp_pos;

  assign id_ok    = 32'(in_task_id) < TASK_SLOTS;
  assign tid_idx  = IDX_W'(tid_r);
  assign in_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res      = res_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    tid_nxt   = tid_r;
    slc_nxt   = slc_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    sm_we     = 1'b0;
    sm_waddr  = idx_r;
    sm_wdata  = '0;
    sm_re     = 1'b0;
    sm_raddr  = idx_r;
    rl_we     = 1'b0;
    rl_waddr  = idx_r;
    rl_wdata  = '0;
    rl_re     = 1'b0;
    rl_raddr  = idx_r;
    sw_pos    = CNT_W'(cur_r) + CNT_W'(1);
    append    = 1'b0;
    disp_pos  = cur_r;

    if (sw_pos >= cnt_r) begin
      sw_pos = '0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // sweep the slot table to its reset image; slot 0 starts running
        sm_we    = 1'b1;
        sm_waddr = idx_r;
        if (idx_r == '0) begin
          sm_wdata.st    = SL_RUN;
          sm_wdata.slice = INIT_SLICE;
        end
        rl_we    = (idx_r == '0);
        rl_waddr = '0;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          tid_nxt = in_task_id;
          slc_nxt = in_slice_ticks;
          res_nxt = '0;
          unique case (in_operation)
            OP_ALLOC: begin
              sm_re     = 1'b1;
              sm_raddr  = '0;
              idx_nxt   = '0;
              state_nxt = S_ALLOC;
            end
            OP_SWITCH: begin
              cur_nxt   = IDX_W'(sw_pos);
              rl_re     = 1'b1;
              rl_raddr  = IDX_W'(sw_pos);
              state_nxt = S_SW_LIST;
            end
            OP_RUN, OP_SLEEP: begin
              if (!id_ok) begin
                res_nxt.status = STS_IGNORED;
                state_nxt      = S_DONE;
              end else begin
                sm_re     = 1'b1;
                sm_raddr  = IDX_W'(in_task_id);
                state_nxt = (in_operation == OP_RUN) ? S_RUN : S_SLP_CHK;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (sm_rdata.st == SL_FREE) begin
          sm_we               = 1'b1;
          sm_waddr            = idx_r;
          sm_wdata.st         = SL_ALLOC;
          sm_wdata.slice      = sm_rdata.slice;
          res_nxt.chosen_task = ID_W'(idx_r);
          state_nxt           = S_DONE;
        end else if (idx_r == LAST_IDX) begin
          res_nxt.status = STS_NO_SLOT;
          state_nxt      = S_DONE;
        end else begin
          sm_re    = 1'b1;
          sm_raddr = idx_r + IDX_W'(1);
          idx_nxt  = idx_r + IDX_W'(1);
        end
      end
      S_RUN: begin
        append         = (sm_rdata.st != SL_RUN) && (cnt_r < FULL_CNT);
        sm_we          = 1'b1;
        sm_waddr       = tid_idx;
        sm_wdata.st    = append ? SL_RUN : sm_rdata.st;
        sm_wdata.slice = (slc_r != '0) ? slc_r : sm_rdata.slice;
        if (append) begin
          rl_we    = 1'b1;
          rl_waddr = IDX_W'(cnt_r);
          rl_wdata = tid_r;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        state_nxt = S_DONE;
      end
      S_SLP_CHK: begin
        if (sm_rdata.st != SL_RUN || cnt_r <= CNT_W'(1)) begin
          res_nxt.status = STS_IGNORED;
          state_nxt      = S_DONE;
        end else begin
          ent_nxt   = sm_rdata;
          rl_re     = 1'b1;
          rl_raddr  = '0;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SLP_WALK;
        end
      end
      S_SLP_WALK: begin
        // one entry per beat: find the sleeper, then move each later entry down
        if (found_r) begin
          rl_we    = 1'b1;
          rl_waddr = idx_r - IDX_W'(1);
          rl_wdata = rl_rdata;
        end else if (rl_rdata == tid_r) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if (CNT_W'(idx_r) + CNT_W'(1) < cnt_r) begin
          rl_re    = 1'b1;
          rl_raddr = idx_r + IDX_W'(1);
          idx_nxt  = idx_r + IDX_W'(1);
        end else begin
          state_nxt = S_SLP_END;
        end
      end
      S_SLP_END: begin
        sm_we          = 1'b1;
        sm_waddr       = tid_idx;
        sm_wdata.st    = SL_ALLOC;
        sm_wdata.slice = ent_r.slice;
        state_nxt      = S_DONE;
        if (found_r) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (pos_r == cur_r) begin
            if (CNT_W'(cur_r) >= cnt_r - CNT_W'(1)) begin
              disp_pos = '0;
            end
            cur_nxt   = disp_pos;
            rl_re     = 1'b1;
            rl_raddr  = disp_pos;
            state_nxt = S_DISP;
          end else if (pos_r < cur_r) begin
            cur_nxt = cur_r - IDX_W'(1);
          end
        end
      end
      S_DISP: begin
        res_nxt.chosen_task = rl_rdata;
        res_nxt.do_jump     = 1'b1;
        state_nxt           = S_DONE;
      end
      S_SW_LIST: begin
        sm_re               = 1'b1;
        sm_raddr            = IDX_W'(rl_rdata);
        res_nxt.chosen_task = rl_rdata;
        state_nxt           = S_SW_SLOT;
      end
      S_SW_SLOT: begin
        res_nxt.timer_reload = 1'b1;
        res_nxt.reload_ticks = sm_rdata.slice;
        res_nxt.do_jump      = (cnt_r >= CNT_W'(2));
        state_nxt            = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cur_r   <= '0;
      cnt_r   <= CNT_W'(1);
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    tid_r <= tid_nxt;
    slc_r <= slc_nxt;
    ent_r <= ent_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== rtl/core/round_robin_task_scheduler_top.sv =====
// Round-robin task scheduler with per-task time slices. The slot table (state and slice
// per task) and the ordered run list each live in a one-read, one-write memory with a
// registered read, so every operation is a short sequence of reads and write-backs and
// one item is handled at a time. After reset the block writes the slot table to its
// initial image (slot 0 running with a slice of 2) with in_ready low. Allocate scans the
// slot table from index 0 for the first free slot; sleep walks the run list to find the
// sleeper and close the gap, then reads the next task when the sleeper was the current
// task; the walks go one memory entry per cycle. A finished result waits in an output
// register, so the next item can be taken while it is still unread; a second result waits
// while that register stays full.
// depends on rrts_pkg, rrts_ctrl, rrts_ram and rrts_out_stage
module round_robin_task_scheduler_top
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ID_W-1:0]    in_task_id,
  input  logic [SLICE_W-1:0] in_slice_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STS_W-1:0]   out_status,
  output logic [ID_W-1:0]    out_chosen_task,
  output logic               out_timer_reload,
  output logic [SLICE_W-1:0] out_reload_ticks,
  output logic               out_do_jump
);

  localparam int IDX_W = $clog2(TASK_SLOTS);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             sm_we, sm_re;
  logic [IDX_W-1:0] sm_waddr, sm_raddr;
  slot_ent_t        sm_wdata, sm_rdata;
  logic             rl_we, rl_re;
  logic [IDX_W-1:0] rl_waddr, rl_raddr;
  logic [ID_W-1:0]  rl_wdata, rl_rdata;

  rrts_ctrl #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_task_id     (in_task_id),
    .in_slice_ticks (in_slice_ticks),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .sm_we          (sm_we),
    .sm_waddr       (sm_waddr),
    .sm_wdata       (sm_wdata),
    .sm_re          (sm_re),
    .sm_raddr       (sm_raddr),
    .sm_rdata       (sm_rdata),
    .rl_we          (rl_we),
    .rl_waddr       (rl_waddr),
    .rl_wdata       (rl_wdata),
    .rl_re          (rl_re),
    .rl_raddr       (rl_raddr),
    .rl_rdata       (rl_rdata)
  );

  rrts_ram #(
    .DEPTH (TASK_SLOTS),
    .WIDTH ($bits(slot_ent_t))
  ) u_slot_mem (
    .clk   (clk),
    .we    (sm_we),
    .waddr (sm_waddr),
    .wdata (sm_wdata),
    .re    (sm_re),
    .raddr (sm_raddr),
    .rdata (sm_rdata)
  );

  rrts_ram #(
    .DEPTH (TASK_SLOTS),
    .WIDTH (ID_W)
  ) u_run_mem (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .re    (rl_re),
    .raddr (rl_raddr),
    .rdata (rl_rdata)
  );

  rrts_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_valid        (res_valid),
    .res              (res),
    .res_ready        (res_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_chosen_task  (out_chosen_task),
    .out_timer_reload (out_timer_reload),
    .out_reload_ticks (out_reload_ticks),
    .out_do_jump      (out_do_jump)
  );

endmodule

// ===== rtl/core/rrts_checker.sv =====
// rrts_checker: port-level assertions for the round-robin task scheduler
// depends on rrts_pkg; bound to round_robin_task_scheduler_top below
module rrts_checker
  import rrts_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [STS_W-1:0]   out_status,
  input logic [ID_W-1:0]    out_chosen_task,
  input logic               out_timer_reload,
  input logic [SLICE_W-1:0] out_reload_ticks,
  input logic               out_do_jump
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_chosen_task) && $stable(out_timer_reload) &&
      $stable(out_reload_ticks) && $stable(out_do_jump))
    else $error("result beat changed while stalled");

  // one item at a time: no second accept right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // refusals and allocation failures carry no dispatch
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |->
      !out_timer_reload && !out_do_jump && out_chosen_task == '0 &&
      out_reload_ticks == '0)
    else $error("non-ok result with dispatch fields set");

  // a timer reload only comes from a successful switch
  a_reload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timer_reload |-> out_status == STS_OK)
    else $error("timer reload on a failed request");

  // ticks are only reported together with a reload
  a_ticks_need_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_timer_reload |-> out_reload_ticks == '0)
    else $error("reload ticks without a reload");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (.*);
